// ===== rtl/core/fmb_pkg.sv =====
// Shared types and codes of the I2C slave frame mailbox.
`default_nettype none

package fmb_pkg;

  // Input operation codes
  localparam logic [2:0] OP_ENQ_START = 3'd0;
  localparam logic [2:0] OP_ENQ_BYTE  = 3'd1;
  localparam logic [2:0] OP_ADDR      = 3'd2;
  localparam logic [2:0] OP_RX_BYTE   = 3'd3;
  localparam logic [2:0] OP_TX_REQ    = 3'd4;
  localparam logic [2:0] OP_STOP      = 3'd5;

  // Result kinds
  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_TX      = 3'd1;
  localparam logic [2:0] KIND_DELIVER = 3'd2;
  localparam logic [2:0] KIND_REJECT  = 3'd3;
  localparam logic [2:0] KIND_EMPTY   = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] length;
    logic [7:0] data;
    logic       master_reads;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_res;
    logic       last;
    logic [5:0] frame_length;
    logic       int_request;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/fmb_chan_if.sv =====
// Valid/ready channel carrying one payload item per transaction.
`default_nettype none

interface fmb_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, input ready, output payload);
  modport sink   (input valid, output ready, input payload);
endinterface

`default_nettype wire

// ===== rtl/core/i2c_slave_frame_mailbox.sv =====
// Frame mailbox for an I2C slave: record ring, frame copy and receive buffer.
//
// in_chan carries one event per transaction (enqueue start/byte, address
// match, bus byte received, bus byte requested, stop); out_chan returns the
// results of each event in order. Most events give one registered result,
// which can be taken in the cycle after accept, so such events can follow
// back to back; a bus byte request first passes S_TX. An address match for a
// master read copies the oldest record out of the ring via S_LD_LEN, S_COPY
// and S_LD_DONE, one byte at a time on the single ring read port. A stop that
// delivers a frame reads the receive buffer once per byte and emits N results
// at one per cycle while out_chan takes them, paced by the buffer read port.
// The block works on one event at a time; in_chan.ready is high only while
// the sequencer is idle and the output register is empty or being taken.
// A stalled out_chan holds its transaction and the sequencer waits on it.
// Reset (rst_n low, synchronous) empties the ring and receive buffer by
// clearing pointers and counters; the memories themselves are not cleared
// and need no clearing pass.
`default_nettype none

module i2c_slave_frame_mailbox #(
  parameter int RING_DEPTH = 512,
  parameter int RX_DEPTH   = 64,
  parameter int MAX_RECORD = 63
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fmb_chan_if.sink    in_chan,
  fmb_chan_if.source  out_chan
);
  import fmb_pkg::*;

  localparam int PTR_W    = $clog2(RING_DEPTH);
  localparam int ROOM_W   = PTR_W + 1;
  localparam int REC_W    = $clog2(MAX_RECORD + 1);
  localparam int POS_W    = $clog2(MAX_RECORD + 2);
  localparam int RXC_W    = $clog2(RX_DEPTH + 1);
  localparam int SLOT_MAX = (RX_DEPTH > MAX_RECORD) ? RX_DEPTH : MAX_RECORD;
  localparam int SLOT_W   = $clog2(SLOT_MAX);
  localparam int AUX_AW   = SLOT_W + 1;
  localparam int AUX_DEPTH = 2 << SLOT_W;

  localparam logic BANK_RX    = 1'b0;
  localparam logic BANK_FRAME = 1'b1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LD_LEN  = 3'd1;
  localparam logic [2:0] S_COPY    = 3'd2;
  localparam logic [2:0] S_LD_DONE = 3'd3;
  localparam logic [2:0] S_TX      = 3'd4;
  localparam logic [2:0] S_DLEN    = 3'd5;
  localparam logic [2:0] S_DOUT    = 3'd6;

  localparam logic [1:0] TX_ZERO = 2'd0;
  localparam logic [1:0] TX_LEN  = 2'd1;
  localparam logic [1:0] TX_MEM  = 2'd2;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Memories
  logic [7:0] ring_mem [RING_DEPTH];
  logic [7:0] aux_mem  [AUX_DEPTH];
  logic [7:0] ring_rdata_r;
  logic [7:0] aux_rdata_r;

  // Control state
  logic [2:0]       state_r, state_nxt;
  logic [PTR_W-1:0] write_ptr_r, write_ptr_nxt;
  logic [PTR_W-1:0] read_ptr_r, read_ptr_nxt;
  logic [PTR_W-1:0] stage_ptr_r, stage_ptr_nxt;
  logic [REC_W-1:0] stage_left_r, stage_left_nxt;
  logic             stage_act_r, stage_act_nxt;
  logic [REC_W-1:0] frame_len_r, frame_len_nxt;
  logic [POS_W-1:0] frame_pos_r, frame_pos_nxt;
  logic             in_write_r, in_write_nxt;
  logic [RXC_W-1:0] rx_cnt_r, rx_cnt_nxt;
  logic             irq_r, irq_nxt;
  logic             out_valid_r;

  // Working registers
  logic [1:0]       tx_src_r, tx_src_nxt;
  logic [REC_W-1:0] cp_iss_r, cp_iss_nxt;
  logic [REC_W-1:0] cp_wr_r, cp_wr_nxt;
  logic [RXC_W-1:0] dlv_len_r, dlv_len_nxt;
  logic [RXC_W-1:0] dlv_idx_r, dlv_idx_nxt;
  out_item_t        out_item_r;

  // Memory ports
  logic              ring_we, ring_re;
  logic [PTR_W-1:0]  ring_waddr;
  logic [7:0]        ring_wdata;
  logic              aux_we, aux_re;
  logic [AUX_AW-1:0] aux_waddr, aux_raddr;
  logic [7:0]        aux_wdata;

  // Result push
  logic       push;
  logic [2:0] push_kind;
  logic [7:0] push_data;
  logic       push_last;
  logic [5:0] push_flen;

  logic              out_free, accept;
  logic [ROOM_W-1:0] room_raw, room;
  logic              len_ok, room_ok;
  logic [RXC_W-1:0]  dlv_n;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && out_free;
  assign accept        = in_chan.valid && in_chan.ready;

  // Free entries, keeping one slot open to tell full from empty
  assign room_raw = ROOM_W'(read_ptr_r) + ROOM_W'(RING_DEPTH - 1) - ROOM_W'(write_ptr_r);
  assign room     = (room_raw >= ROOM_W'(RING_DEPTH)) ? room_raw - ROOM_W'(RING_DEPTH)
                                                       : room_raw;
  assign len_ok   = (in_chan.payload.length != 8'd0) &&
                    (in_chan.payload.length <= 8'(MAX_RECORD));
  assign room_ok  = room > ROOM_W'(in_chan.payload.length);

  assign dlv_n = (aux_rdata_r < 8'(dlv_len_r)) ? RXC_W'(aux_rdata_r) : dlv_len_r;

  always_comb begin
    state_nxt      = state_r;
    write_ptr_nxt  = write_ptr_r;
    read_ptr_nxt   = read_ptr_r;
    stage_ptr_nxt  = stage_ptr_r;
    stage_left_nxt = stage_left_r;
    stage_act_nxt  = stage_act_r;
    frame_len_nxt  = frame_len_r;
    frame_pos_nxt  = frame_pos_r;
    in_write_nxt   = in_write_r;
    rx_cnt_nxt     = rx_cnt_r;
    irq_nxt        = irq_r;
    tx_src_nxt     = tx_src_r;
    cp_iss_nxt     = cp_iss_r;
    cp_wr_nxt      = cp_wr_r;
    dlv_len_nxt    = dlv_len_r;
    dlv_idx_nxt    = dlv_idx_r;
    ring_we        = 1'b0;
    ring_re        = 1'b0;
    ring_waddr     = write_ptr_r;
    ring_wdata     = in_chan.payload.length;
    aux_we         = 1'b0;
    aux_re         = 1'b0;
    aux_waddr      = {BANK_RX, SLOT_W'(rx_cnt_r)};
    aux_wdata      = in_chan.payload.data;
    aux_raddr      = {BANK_RX, SLOT_W'(0)};
    push           = 1'b0;
    push_kind      = KIND_ACK;
    push_data      = 8'd0;
    push_last      = 1'b0;
    push_flen      = 6'd0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_chan.payload.op)
            OP_ENQ_START: begin
              push          = 1'b1;
              stage_act_nxt = 1'b0;
              if (len_ok && room_ok) begin
                ring_we        = 1'b1;
                ring_waddr     = write_ptr_r;
                ring_wdata     = in_chan.payload.length;
                stage_ptr_nxt  = ring_next(write_ptr_r);
                stage_left_nxt = REC_W'(in_chan.payload.length);
                stage_act_nxt  = 1'b1;
              end else begin
                push_kind = KIND_REJECT;
              end
            end
            OP_ENQ_BYTE: begin
              push = 1'b1;
              if (stage_act_r) begin
                ring_we        = 1'b1;
                ring_waddr     = stage_ptr_r;
                ring_wdata     = in_chan.payload.data;
                stage_ptr_nxt  = ring_next(stage_ptr_r);
                stage_left_nxt = stage_left_r - 1'b1;
                // Commit the record after its last byte
                if (stage_left_r == REC_W'(1)) begin
                  write_ptr_nxt = ring_next(stage_ptr_r);
                  stage_act_nxt = 1'b0;
                  irq_nxt       = 1'b1;
                end
              end
            end
            OP_ADDR: begin
              if (in_chan.payload.master_reads) begin
                in_write_nxt  = 1'b0;
                frame_pos_nxt = '0;
                if (read_ptr_r == write_ptr_r) begin
                  frame_len_nxt = '0;
                  push          = 1'b1;
                end else begin
                  ring_re      = 1'b1;
                  read_ptr_nxt = ring_next(read_ptr_r);
                  state_nxt    = S_LD_LEN;
                end
              end else begin
                in_write_nxt = 1'b1;
                rx_cnt_nxt   = '0;
                push         = 1'b1;
              end
            end
            OP_RX_BYTE: begin
              push = 1'b1;
              if (in_write_r && (rx_cnt_r < RXC_W'(RX_DEPTH))) begin
                aux_we     = 1'b1;
                aux_waddr  = {BANK_RX, SLOT_W'(rx_cnt_r)};
                aux_wdata  = in_chan.payload.data;
                rx_cnt_nxt = rx_cnt_r + 1'b1;
              end
            end
            OP_TX_REQ: begin
              state_nxt = S_TX;
              if (frame_pos_r <= POS_W'(frame_len_r)) begin
                frame_pos_nxt = frame_pos_r + 1'b1;
                if (frame_pos_r == '0) begin
                  tx_src_nxt = TX_LEN;
                end else begin
                  tx_src_nxt = TX_MEM;
                  aux_re     = 1'b1;
                  aux_raddr  = {BANK_FRAME, SLOT_W'(frame_pos_r - 1'b1)};
                end
              end else begin
                tx_src_nxt = TX_ZERO;
              end
            end
            OP_STOP: begin
              in_write_nxt = 1'b0;
              rx_cnt_nxt   = '0;
              if (in_write_r && (rx_cnt_r >= RXC_W'(2))) begin
                // Fetch the declared length byte first
                dlv_len_nxt = rx_cnt_r - 1'b1;
                aux_re      = 1'b1;
                aux_raddr   = {BANK_RX, SLOT_W'(0)};
                state_nxt   = S_DLEN;
              end else begin
                push = 1'b1;
              end
            end
            default: push = 1'b1;
          endcase
        end
      end

      S_LD_LEN: begin
        frame_len_nxt = REC_W'(ring_rdata_r);
        ring_re       = 1'b1;
        read_ptr_nxt  = ring_next(read_ptr_r);
        cp_iss_nxt    = REC_W'(1);
        cp_wr_nxt     = '0;
        state_nxt     = S_COPY;
      end

      S_COPY: begin
        // Write the byte read last cycle, keep one read in flight
        aux_we    = 1'b1;
        aux_waddr = {BANK_FRAME, SLOT_W'(cp_wr_r)};
        aux_wdata = ring_rdata_r;
        if (cp_iss_r < frame_len_r) begin
          ring_re      = 1'b1;
          read_ptr_nxt = ring_next(read_ptr_r);
          cp_iss_nxt   = cp_iss_r + 1'b1;
        end
        if (REC_W'(cp_wr_r + 1'b1) == frame_len_r) begin
          state_nxt = S_LD_DONE;
        end else begin
          cp_wr_nxt = cp_wr_r + 1'b1;
        end
      end

      S_LD_DONE: begin
        if (out_free) begin
          if (read_ptr_r == write_ptr_r) begin
            irq_nxt = 1'b0;
          end
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_TX: begin
        if (out_free) begin
          push      = 1'b1;
          push_kind = KIND_TX;
          case (tx_src_r)
            TX_LEN:  push_data = 8'(frame_len_r);
            TX_MEM:  push_data = aux_rdata_r;
            default: push_data = 8'd0;
          endcase
          state_nxt = S_IDLE;
        end
      end

      S_DLEN: begin
        if (out_free) begin
          if (dlv_n == '0) begin
            push      = 1'b1;
            push_kind = KIND_EMPTY;
            state_nxt = S_IDLE;
          end else begin
            dlv_len_nxt = dlv_n;
            dlv_idx_nxt = RXC_W'(1);
            aux_re      = 1'b1;
            aux_raddr   = {BANK_RX, SLOT_W'(1)};
            state_nxt   = S_DOUT;
          end
        end
      end

      S_DOUT: begin
        if (out_free) begin
          push      = 1'b1;
          push_kind = KIND_DELIVER;
          push_data = aux_rdata_r;
          push_last = (dlv_idx_r == dlv_len_r);
          push_flen = 6'(dlv_len_r);
          if (dlv_idx_r == dlv_len_r) begin
            state_nxt = S_IDLE;
          end else begin
            // Prefetch the next byte while this one leaves
            aux_re      = 1'b1;
            aux_raddr   = {BANK_RX, SLOT_W'(dlv_idx_r + 1'b1)};
            dlv_idx_nxt = dlv_idx_r + 1'b1;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rdata_r <= ring_mem[read_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (aux_we) begin
      aux_mem[aux_waddr] <= aux_wdata;
    end
    if (aux_re) begin
      aux_rdata_r <= aux_mem[aux_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      write_ptr_r  <= '0;
      read_ptr_r   <= '0;
      stage_ptr_r  <= '0;
      stage_left_r <= '0;
      stage_act_r  <= 1'b0;
      frame_len_r  <= '0;
      frame_pos_r  <= '0;
      in_write_r   <= 1'b0;
      rx_cnt_r     <= '0;
      irq_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      write_ptr_r  <= write_ptr_nxt;
      read_ptr_r   <= read_ptr_nxt;
      stage_ptr_r  <= stage_ptr_nxt;
      stage_left_r <= stage_left_nxt;
      stage_act_r  <= stage_act_nxt;
      frame_len_r  <= frame_len_nxt;
      frame_pos_r  <= frame_pos_nxt;
      in_write_r   <= in_write_nxt;
      rx_cnt_r     <= rx_cnt_nxt;
      irq_r        <= irq_nxt;
      out_valid_r  <= push || (out_valid_r && !out_chan.ready);
    end
  end

  always_ff @(posedge clk) begin
    tx_src_r  <= tx_src_nxt;
    cp_iss_r  <= cp_iss_nxt;
    cp_wr_r   <= cp_wr_nxt;
    dlv_len_r <= dlv_len_nxt;
    dlv_idx_r <= dlv_idx_nxt;
    if (push) begin
      out_item_r.kind         <= push_kind;
      out_item_r.data_res     <= push_data;
      out_item_r.last         <= push_last;
      out_item_r.frame_length <= push_flen;
      out_item_r.int_request  <= irq_nxt;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/core/fmb_checker.sv =====
// Port-level checks for the frame mailbox, bound to the top level.
`default_nettype none

module fmb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire fmb_pkg::out_item_t out_item
);
  import fmb_pkg::*;

  // A stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Never take an event while an untaken result would be overwritten
  a_in_gated: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("input ready while output blocked");

  // The last marker belongs to a delivered frame byte only
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> out_item.kind == KIND_DELIVER)
    else $error("last set on a non-delivery result");

  // Delivered bytes always report a non-empty frame
  a_deliver_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_DELIVER |-> out_item.frame_length != 6'd0)
    else $error("delivered byte with zero frame length");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind i2c_slave_frame_mailbox fmb_checker u_fmb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_item  (out_chan.payload)
);

`default_nettype wire

// ===== tb/i2c_slave_frame_mailbox_test.sv =====
// Testbench for the I2C slave frame mailbox: directed and random events checked by a predictor.
`default_nettype none

module i2c_slave_frame_mailbox_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fmb_pkg::*;

  localparam int RING_DEPTH = 512;
  localparam int RX_DEPTH   = 64;
  localparam int MAX_RECORD = 63;
  localparam int RANDOM_EVENTS = 260;

  typedef struct {
    in_item_t   item;
    logic [1:0] mode;   // 0 free flow, 1 sender idles, 2 receiver stalls, 3 both
  } queued_event_t;

  logic clk;
  logic rst_n;

  fmb_chan_if #(.T(in_item_t))  in_if ();
  fmb_chan_if #(.T(out_item_t)) out_if ();

  i2c_slave_frame_mailbox #(
    .RING_DEPTH(RING_DEPTH),
    .RX_DEPTH  (RX_DEPTH),
    .MAX_RECORD(MAX_RECORD)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  queued_event_t pending_events[$];
  out_item_t     expected_results[$];
  int            pushed_events = 0;
  int            mismatches = 0;
  logic [1:0]    stall_mode = 2'd0;

  // Mailbox state as the predictor sees it
  logic [7:0] mb_ring [RING_DEPTH];
  logic [8:0] mb_wr = '0;
  logic [8:0] mb_rd = '0;
  logic [8:0] mb_stage = '0;
  logic [5:0] mb_stage_left = '0;
  logic       mb_staging = 1'b0;
  logic [7:0] mb_frame [64];
  logic [5:0] mb_frame_len = '0;
  logic [6:0] mb_frame_pos = '0;
  logic       mb_writing = 1'b0;
  logic [7:0] mb_rx [RX_DEPTH];
  logic [6:0] mb_rx_count = '0;
  logic       mb_irq = 1'b0;

  task automatic push_result(input logic [2:0] kind, input logic [7:0] d, input logic l,
                             input logic [5:0] flen);
    out_item_t r;
    r.kind         = kind;
    r.data_res     = d;
    r.last         = l;
    r.frame_length = flen;
    r.int_request  = mb_irq;
    expected_results.push_back(r);
  endtask

  task automatic predict_mailbox_results(input in_item_t ev);
    logic [8:0] room;
    logic [8:0] p;
    logic [6:0] n;
    logic [7:0] b;
    case (ev.op)
      OP_ENQ_START: begin
        mb_staging = 1'b0;
        room = mb_rd - mb_wr - 9'd1;
        if (ev.length == 8'd0 || ev.length > MAX_RECORD || int'(room) < int'(ev.length) + 1) begin
          push_result(KIND_REJECT, 8'd0, 1'b0, 6'd0);
        end else begin
          mb_ring[mb_wr] = ev.length;
          mb_stage = mb_wr + 9'd1;
          mb_stage_left = ev.length[5:0];
          mb_staging = 1'b1;
          push_result(KIND_ACK, 8'd0, 1'b0, 6'd0);
        end
      end
      OP_ENQ_BYTE: begin
        if (mb_staging) begin
          mb_ring[mb_stage] = ev.data;
          mb_stage = mb_stage + 9'd1;
          mb_stage_left = mb_stage_left - 6'd1;
          // commit once the last payload byte lands
          if (mb_stage_left == 6'd0) begin
            mb_wr = mb_stage;
            mb_staging = 1'b0;
            mb_irq = 1'b1;
          end
        end
        push_result(KIND_ACK, 8'd0, 1'b0, 6'd0);
      end
      OP_ADDR: begin
        if (ev.master_reads) begin
          mb_writing = 1'b0;
          mb_frame_pos = '0;
          if (mb_rd == mb_wr) begin
            mb_frame_len = '0;
          end else begin
            p = mb_rd;
            n = (mb_ring[p] > MAX_RECORD) ? 7'(MAX_RECORD) : mb_ring[p][6:0];
            p = p + 9'd1;
            for (int i = 0; i < n; i++) begin
              mb_frame[i] = mb_ring[p];
              p = p + 9'd1;
            end
            mb_frame_len = n[5:0];
            mb_rd = p;
            if (mb_rd == mb_wr) mb_irq = 1'b0;
          end
        end else begin
          mb_writing = 1'b1;
          mb_rx_count = '0;
        end
        push_result(KIND_ACK, 8'd0, 1'b0, 6'd0);
      end
      OP_RX_BYTE: begin
        if (mb_writing && mb_rx_count < RX_DEPTH) begin
          mb_rx[mb_rx_count] = ev.data;
          mb_rx_count = mb_rx_count + 7'd1;
        end
        push_result(KIND_ACK, 8'd0, 1'b0, 6'd0);
      end
      OP_TX_REQ: begin
        b = 8'd0;
        if (mb_frame_pos <= mb_frame_len) begin
          b = (mb_frame_pos == 7'd0) ? {2'b00, mb_frame_len} : mb_frame[mb_frame_pos - 7'd1];
          mb_frame_pos = mb_frame_pos + 7'd1;
        end
        push_result(KIND_TX, b, 1'b0, 6'd0);
      end
      OP_STOP: begin
        if (mb_writing && mb_rx_count >= 7'd2) begin
          n = mb_rx_count - 7'd1;
          if (mb_rx[0] < n) n = mb_rx[0][6:0];
          mb_writing = 1'b0;
          mb_rx_count = '0;
          if (n == 7'd0) begin
            push_result(KIND_EMPTY, 8'd0, 1'b0, 6'd0);
          end else begin
            for (int i = 0; i < n; i++)
              push_result(KIND_DELIVER, mb_rx[i + 1], (i + 1 == n), n[5:0]);
          end
        end else begin
          mb_writing = 1'b0;
          mb_rx_count = '0;
          push_result(KIND_ACK, 8'd0, 1'b0, 6'd0);
        end
      end
      default: begin
        push_result(KIND_ACK, 8'd0, 1'b0, 6'd0);
      end
    endcase
  endtask

  task automatic push_event(input logic [2:0] op, input logic [7:0] len, input logic [7:0] d,
                            input logic mr);
    queued_event_t e;
    e.item.op           = op;
    e.item.length       = len;
    e.item.data         = d;
    e.item.master_reads = mr;
    e.mode = 2'((pushed_events / 50) % 4);
    pushed_events++;
    pending_events.push_back(e);
  endtask

  task automatic add_record(input logic [7:0] len, input int nbytes);
    push_event(OP_ENQ_START, len, 8'($urandom), 1'($urandom));
    for (int i = 0; i < nbytes; i++)
      push_event(OP_ENQ_BYTE, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic add_read(input int nreq);
    push_event(OP_ADDR, 8'($urandom), 8'($urandom), 1'b1);
    for (int i = 0; i < nreq; i++)
      push_event(OP_TX_REQ, 8'($urandom), 8'($urandom), 1'($urandom));
    push_event(OP_STOP, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic add_write(input int nbytes, input logic [7:0] first);
    push_event(OP_ADDR, 8'($urandom), 8'($urandom), 1'b0);
    for (int i = 0; i < nbytes; i++)
      push_event(OP_RX_BYTE, 8'($urandom), (i == 0) ? first : 8'($urandom), 1'($urandom));
    push_event(OP_STOP, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic build_directed();
    push_event(OP_TX_REQ, 8'd0, 8'd0, 1'b0);       // request before any read
    push_event(OP_ADDR, 8'd0, 8'd0, 1'b1);         // read from an empty ring
    push_event(OP_TX_REQ, 8'd0, 8'd0, 1'b0);
    push_event(OP_ENQ_START, 8'd0, 8'd0, 1'b0);    // invalid lengths
    push_event(OP_ENQ_START, 8'd64, 8'd0, 1'b0);
    push_event(OP_ENQ_START, 8'd255, 8'd0, 1'b1);
    push_event(OP_ENQ_BYTE, 8'd0, 8'hFF, 1'b0);    // stray byte, nothing staging
    push_event(OP_ENQ_START, 8'd2, 8'd0, 1'b0);
    push_event(OP_ENQ_BYTE, 8'd0, 8'h5A, 1'b0);
    push_event(OP_ENQ_START, 8'd1, 8'd0, 1'b0);    // restart drops the partial record
    push_event(OP_ENQ_BYTE, 8'd0, 8'hFF, 1'b0);
    push_event(OP_ENQ_START, 8'd1, 8'd0, 1'b0);
    push_event(OP_ENQ_BYTE, 8'd0, 8'h00, 1'b0);
    push_event(OP_ADDR, 8'd0, 8'd0, 1'b1);
    repeat (3) push_event(OP_TX_REQ, 8'd0, 8'd0, 1'b0);  // length, payload, past the end
    push_event(OP_STOP, 8'd0, 8'd0, 1'b0);
    push_event(OP_ADDR, 8'd0, 8'd0, 1'b1);         // drains the ring, drops the request line
    push_event(OP_RX_BYTE, 8'd0, 8'h77, 1'b0);     // bus byte outside a write
    add_write(0, 8'd0);                            // short writes
    add_write(1, 8'h33);
    add_write(2, 8'h00);                           // declared length zero
    push_event(OP_ADDR, 8'd0, 8'd0, 1'b0);
    push_event(OP_RX_BYTE, 8'd0, 8'd5, 1'b0);      // declares more than it sends
    push_event(OP_RX_BYTE, 8'd0, 8'h12, 1'b0);
    push_event(OP_RX_BYTE, 8'd0, 8'hED, 1'b0);
    push_event(OP_STOP, 8'd0, 8'd0, 1'b0);
    push_event(3'd6, 8'hFF, 8'hFF, 1'b1);          // unused op codes
    push_event(3'd7, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic build_random();
    int base;
    int sel;
    int r;
    int k;
    logic [7:0] len;
    base = pending_events.size();
    while (pending_events.size() - base < RANDOM_EVENTS) begin
      sel = $urandom_range(99);
      r = $urandom_range(99);
      if (sel < 35) begin
        if (r < 10) begin
          len = $urandom_range(1) ? 8'd0 : 8'($urandom_range(64, 255));
          k = $urandom_range(0, 2);
        end else begin
          len = (r < 30) ? 8'($urandom_range(32, 63)) : 8'($urandom_range(1, 8));
          k = ($urandom_range(9) == 0) ? $urandom_range(0, len - 1) : int'(len);
        end
        add_record(len, k);
      end else if (sel < 60) begin
        add_read(($urandom_range(9) == 0) ? $urandom_range(0, 66) : $urandom_range(0, 6));
      end else if (sel < 80) begin
        k = (r < 15) ? $urandom_range(0, 1) :
            (r < 25) ? $urandom_range(63, 66) : $urandom_range(2, 10);
        add_write(k, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, k)));
      end else begin
        push_event(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // Driver: present the head event, hold it until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_mailbox_results(in_if.payload);
        void'(pending_events.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_events.size() > 0 &&
            $urandom_range(99) >= ((pending_events[0].mode == 2'd1) ? 77 :
                                   (pending_events[0].mode == 2'd3) ? 32 : 0)) begin
          in_if.valid   <= 1'b1;
          in_if.payload <= pending_events[0].item;
          stall_mode    <= pending_events[0].mode;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d data %02h last %0b len %0d irq %0b",
                     got.kind, got.data_res, got.last, got.frame_length, got.int_request);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.data_res !== want.data_res ||
              got.last !== want.last || got.frame_length !== want.frame_length ||
              got.int_request !== want.int_request) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch (exp/got): kind %0d/%0d data %02h/%02h last %0b/%0b ",
                        "len %0d/%0d irq %0b/%0b"},
                       want.kind, got.kind, want.data_res, got.data_res, want.last, got.last,
                       want.frame_length, got.frame_length, want.int_request, got.int_request);
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= ((stall_mode == 2'd2) ? 77 :
                                              (stall_mode == 2'd3) ? 32 : 0));
    end
  end

  initial begin
    rst_n = 1'b0;
    build_directed();
    build_random();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_events.size() != 0) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
